>>> sv/sweep_averager_peak_decimator_core_macros.svh
// Assertion macros for the sweep averager RTL.
`ifndef SWEEP_AVERAGER_PEAK_DECIMATOR_CORE_MACROS_SVH
`define SWEEP_AVERAGER_PEAK_DECIMATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted.
`define SPD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset too.
`define SPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define SPD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> sv/spd_pkg.sv
// Package: types and constants of the sweep averager with peak-hold decimation.
`default_nettype none

package spd_pkg;

    // Store geometry; MAX_RECORD is a power of two.
    localparam int MAX_RECORD = 32768;
    localparam int ACC_WIDTH  = 24;
    localparam int ADDR_W     = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 15;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_AVG_LOG2  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_COUNT = 2'd2;

    localparam logic [3:0] AVG_LOG2_RESET  = 4'd4;
    localparam logic [7:0] BIN_SIZE_RESET  = 8'd100;
    localparam logic [8:0] BIN_COUNT_RESET = 9'd200;

    localparam logic [3:0] AVG_LOG2_MAX  = 4'd8;
    localparam logic [7:0] BIN_SIZE_MAX  = 8'd128;
    localparam logic [8:0] BIN_COUNT_MAX = 9'd256;

    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] sample_raw;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       bin_index;
        logic [11:0]      bin_value;
        logic [11:0]      peak_amp;
        logic [POS_W-1:0] peak_index;
        logic             last_bin;
    } t_out_item;

    // Per-sample control from the sequencer to the accumulate stage.
    typedef struct packed {
        logic                is_clear;
        logic                first_sweep;
        logic                final_sweep;
        logic                bin_end;
        logic                sweep_end;
        logic [3:0]          k;
        logic [7:0]          bin_index;
        logic [POS_W-1:0]    bin_start;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] val;
    } t_s0_ctl;

endpackage

`default_nettype wire

>>> sv/sweep_averager_peak_decimator_core.sv
// Top level of the coherent sweep averager with peak-hold decimation.
`default_nettype none

// Coherent sweep averager with peak-hold decimation. Each sample transaction
// carries one byte-swapped ADC word; the word is swapped back and summed into a
// per-position accumulator held in a single-port-write / single-port-read RAM
// of MAX_RECORD x ACC_WIDTH (sums saturate). The first sweep of an average
// writes without adding, so the store needs no clearing pass after reset. On
// sweep 2^avg_log2 each sum is shifted down by avg_log2 (capped at 65535) and
// a peak is held per bin; at the end of each bin one result transaction gives
// the bin peak / 16, and the last bin also carries the global peak / 16 and the
// start sample of the earliest bin that reached it. A clear transaction
// (req_type = 1) restarts the average at sweep start.
// Throughput: one sample per clock while the output is not stalled. A sample
// is accepted, its accumulator entry is read in that cycle and written back
// from the stage register; a write-to-read bypass covers the same entry coming
// back on the next sample (very short sweeps, sweep wrap). Input ready drops
// only while the result stage holds a result and the output register is full
// and not being taken. Registers: 0 avg_log2, 1 bin_size, 2 bin_count;
// configuration writes are always accepted and take effect at once, so write
// them only while the block is idle.

module sweep_averager_peak_decimator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [spd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire spd_pkg::t_in_item               i_in_data,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output spd_pkg::t_out_item                   o_out_data
);

    logic                                accept;
    spd_pkg::t_s0_ctl                    ctl;
    logic                                ready;
    logic [spd_pkg::ACC_WIDTH-1:0]       rd_data;
    logic                                wr_en;
    logic [spd_pkg::ADDR_W-1:0]          wr_addr;
    logic [spd_pkg::ACC_WIDTH-1:0]       wr_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ready;
    assign accept      = i_in_valid && ready;

    // Counters and address for the sample at the input
    spd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_accept    (accept),
        .o_ctl       (ctl)
    );

    // Accumulator store; read is launched on the accept edge
    spd_ram #(
        .DEPTH (spd_pkg::MAX_RECORD),
        .WIDTH (spd_pkg::ACC_WIDTH),
        .AW    (spd_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (ctl.addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Add, write back, peak hold and result register
    spd_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_ctl       (ctl),
        .o_ready     (ready),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> sv/spd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module spd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> sv/spd_seq.sv
// Sweep sequencer: config registers, position/bin/sweep counters, store address.
`default_nettype none

module spd_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [spd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire spd_pkg::t_in_item               i_in_data,
    input  wire logic                            i_accept,
    output spd_pkg::t_s0_ctl                     o_ctl
);

    logic [3:0] r_avg_log2;
    logic [7:0] r_bin_size;
    logic [8:0] r_bin_count;

    logic [8:0]                r_sweep, n_sweep;
    logic [6:0]                r_sib, n_sib;
    logic [7:0]                r_bin, n_bin;
    logic [spd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [spd_pkg::POS_W-1:0] r_bin_start, n_bin_start;

    logic [3:0]  k_eff;
    logic [7:0]  bs_eff;
    logic [8:0]  bc_eff;
    logic [7:0]  sib_p1;
    logic [8:0]  bin_p1;
    logic [9:0]  sweep_p1;
    logic [9:0]  sweeps_needed;
    logic        bin_end;
    logic        sweep_end;
    logic        final_sweep;
    logic [spd_pkg::POS_W-1:0] pos_p1;
    logic [31:0] pos_ext;

    // Out-of-range register values are clamped.
    always_comb begin
        k_eff  = (r_avg_log2 > spd_pkg::AVG_LOG2_MAX) ? spd_pkg::AVG_LOG2_MAX : r_avg_log2;
        bs_eff = (r_bin_size == 8'd0) ? 8'd1
               : ((r_bin_size > spd_pkg::BIN_SIZE_MAX) ? spd_pkg::BIN_SIZE_MAX : r_bin_size);
        bc_eff = (r_bin_count == 9'd0) ? 9'd1
               : ((r_bin_count > spd_pkg::BIN_COUNT_MAX) ? spd_pkg::BIN_COUNT_MAX
                                                         : r_bin_count);
    end

    always_comb begin
        sib_p1        = {1'b0, r_sib} + 8'd1;
        bin_p1        = {1'b0, r_bin} + 9'd1;
        sweep_p1      = {1'b0, r_sweep} + 10'd1;
        sweeps_needed = 10'd1 << k_eff;
        bin_end       = (sib_p1 >= bs_eff);
        sweep_end     = bin_end && (bin_p1 >= bc_eff);
        final_sweep   = (sweep_p1 >= sweeps_needed);
        pos_p1        = r_pos + 15'd1;
        pos_ext       = {17'd0, r_pos};
    end

    always_comb begin
        o_ctl.is_clear    = i_in_data.req_type;
        o_ctl.first_sweep = (r_sweep == 9'd0);
        o_ctl.final_sweep = final_sweep;
        o_ctl.bin_end     = bin_end;
        o_ctl.sweep_end   = sweep_end;
        o_ctl.k           = k_eff;
        o_ctl.bin_index   = r_bin;
        o_ctl.bin_start   = r_bin_start;
        o_ctl.addr        = pos_ext[spd_pkg::ADDR_W-1:0];
        o_ctl.val         = {i_in_data.sample_raw[7:0], i_in_data.sample_raw[15:8]};
    end

    always_comb begin
        n_sweep     = r_sweep;
        n_sib       = r_sib;
        n_bin       = r_bin;
        n_pos       = r_pos;
        n_bin_start = r_bin_start;
        if (i_accept) begin
            if (i_in_data.req_type) begin
                n_sweep     = 9'd0;
                n_sib       = 7'd0;
                n_bin       = 8'd0;
                n_pos       = '0;
                n_bin_start = '0;
            end else if (sweep_end) begin
                n_sweep     = final_sweep ? 9'd0 : sweep_p1[8:0];
                n_sib       = 7'd0;
                n_bin       = 8'd0;
                n_pos       = '0;
                n_bin_start = '0;
            end else if (bin_end) begin
                n_sib       = 7'd0;
                n_bin       = bin_p1[7:0];
                n_pos       = pos_p1;
                n_bin_start = pos_p1;
            end else begin
                n_sib       = sib_p1[6:0];
                n_pos       = pos_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= 9'd0;
            r_sib       <= 7'd0;
            r_bin       <= 8'd0;
            r_pos       <= '0;
            r_bin_start <= '0;
        end else begin
            r_sweep     <= n_sweep;
            r_sib       <= n_sib;
            r_bin       <= n_bin;
            r_pos       <= n_pos;
            r_bin_start <= n_bin_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_log2  <= spd_pkg::AVG_LOG2_RESET;
            r_bin_size  <= spd_pkg::BIN_SIZE_RESET;
            r_bin_count <= spd_pkg::BIN_COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spd_pkg::CFG_AVG_LOG2:  r_avg_log2  <= i_cfg_data[3:0];
                spd_pkg::CFG_BIN_SIZE:  r_bin_size  <= i_cfg_data[7:0];
                spd_pkg::CFG_BIN_COUNT: r_bin_count <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/spd_acc.sv
// Accumulate stage: store read-modify-write, forwarding, peak hold, result register.
`default_nettype none
`include "sweep_averager_peak_decimator_core_macros.svh"

module spd_acc (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire spd_pkg::t_s0_ctl                    i_ctl,
    output logic                                     o_ready,
    input  wire logic [spd_pkg::ACC_WIDTH-1:0]       i_rd_data,
    output logic                                     o_wr_en,
    output logic      [spd_pkg::ADDR_W-1:0]          o_wr_addr,
    output logic      [spd_pkg::ACC_WIDTH-1:0]       o_wr_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output spd_pkg::t_out_item                       o_out_data
);

    localparam int AW = spd_pkg::ACC_WIDTH;

    logic                r_s1_valid;
    spd_pkg::t_s0_ctl    r_s1;
    logic                r_fwd;
    logic [AW-1:0]       r_fwd_data;

    logic [15:0]               r_local, n_local;
    logic [15:0]               r_global, n_global;
    logic [spd_pkg::POS_W-1:0] r_gpos, n_gpos;

    logic                r_out_valid;
    spd_pkg::t_out_item  r_out;

    logic [AW-1:0]       acc_old;
    logic [AW:0]         sum_w;
    logic [AW-1:0]       sum_sat;
    logic [AW-1:0]       sum_sh;
    logic [15:0]         avg;
    logic [15:0]         lp;
    logic [15:0]         gp;
    logic [spd_pkg::POS_W-1:0] gpos;
    logic                has_result;
    logic                s1_adv;
    logic                fwd_hit;
    spd_pkg::t_out_item  res;

    // Write from the previous item lands at the same edge as this read.
    assign acc_old = r_fwd ? r_fwd_data : i_rd_data;

    always_comb begin
        sum_w   = r_s1.first_sweep ? (AW+1)'(r_s1.val)
                                   : ({1'b0, acc_old} + (AW+1)'(r_s1.val));
        sum_sat = sum_w[AW] ? '1 : sum_w[AW-1:0];
        sum_sh  = sum_sat >> r_s1.k;
        avg     = (sum_sh > AW'(32'h0000_FFFF)) ? 16'hFFFF : sum_sh[15:0];
    end

    assign has_result = r_s1_valid && !r_s1.is_clear && r_s1.final_sweep && r_s1.bin_end;
    assign s1_adv     = !has_result || !r_out_valid || i_out_ready;
    assign o_ready    = !r_s1_valid || s1_adv;

    assign o_wr_en   = r_s1_valid && !r_s1.is_clear && s1_adv;
    assign o_wr_addr = r_s1.addr;
    assign o_wr_data = sum_sat;
    assign fwd_hit   = o_wr_en && (o_wr_addr == i_ctl.addr);

    // Peak hold
    always_comb begin
        lp   = (r_s1.final_sweep && (avg > r_local)) ? avg : r_local;
        gp   = r_global;
        gpos = r_gpos;
        if (r_s1.final_sweep && r_s1.bin_end && (lp > r_global)) begin
            gp   = lp;
            gpos = r_s1.bin_start;
        end

        res.bin_index  = r_s1.bin_index;
        res.bin_value  = lp[15:4];
        res.peak_amp   = r_s1.sweep_end ? gp[15:4] : 12'd0;
        res.peak_index = r_s1.sweep_end ? gpos : '0;
        res.last_bin   = r_s1.sweep_end;

        n_local  = r_local;
        n_global = r_global;
        n_gpos   = r_gpos;
        if (r_s1_valid && s1_adv) begin
            if (r_s1.is_clear || r_s1.sweep_end) begin
                n_local  = 16'd0;
                n_global = 16'd0;
                n_gpos   = '0;
            end else begin
                n_local  = r_s1.bin_end ? 16'd0 : lp;
                n_global = gp;
                n_gpos   = gpos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_local    <= 16'd0;
            r_global   <= 16'd0;
            r_gpos     <= '0;
        end else begin
            r_local  <= n_local;
            r_global <= n_global;
            r_gpos   <= n_gpos;
            if (i_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= fwd_hit;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1       <= i_ctl;
            r_fwd_data <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (has_result && s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (has_result && s1_adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SPD_ASSERT_CLK(a_fwd_set, i_clk, i_rst_n, (i_accept && fwd_hit) |=> r_fwd, "same-entry write not forwarded")

    `SPD_ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, (has_result && r_out_valid && !i_out_ready) |=> (r_s1_valid && $stable(r_s1.addr)), "stalled sample lost")

    `SPD_ASSERT_CLK(a_ready_low, i_clk, i_rst_n, !o_ready |-> (r_s1_valid && r_out_valid && !i_out_ready), "input blocked without output stall")

    `SPD_ASSERT_CLK(a_peak_only_last, i_clk, i_rst_n, (r_out_valid && !r_out.last_bin) |-> (r_out.peak_amp == 12'd0 && r_out.peak_index == '0), "peak fields set on non-final bin")

endmodule

`default_nettype wire
